>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the pot/servo drive RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock edge, disabled while in reset.
`define POTSRV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a property in the next.
`define POTSRV_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> sv/potsrv_pkg.sv
// ----------------------------------------------------------------------------
// potsrv_pkg
// Constants and derived widths for the pot average to motor/servo drive.
// ----------------------------------------------------------------------------
package potsrv_pkg;

	localparam int WINDOW      = 10;
	localparam int SAMPLE_BITS = 10;

	localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
	localparam int AVG_DEN    = FULL_SCALE * WINDOW;

	localparam int SPEED_SPAN = 198;
	localparam int SPEED_MAX  = 99;
	localparam int ANGLE_SPAN = 180;
	localparam int ANGLE_MID  = 90;
	localparam int MOTOR_TOP  = 1999;
	localparam int SERVO_STEP = 50;
	localparam int SERVO_BASE = 2999;

	// port field widths
	localparam int SPEED_SAMPLE_W  = 10;
	localparam int ANGLE_SAMPLE_W  = 10;
	localparam int SPEED_SETTING_W = 8;
	localparam int ABS_SPEED_W     = 7;
	localparam int ABS_ANGLE_W     = 8;
	localparam int ANGLE_SETTING_W = 8;
	localparam int MOTOR_PULSE_W   = 11;
	localparam int SERVO_PULSE_W   = 14;

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = $clog2(AVG_DEN + 1);

	// sum * span, and the rounded-up variant for negative speeds
	localparam int X_W         = $clog2(AVG_DEN * SPEED_SPAN + AVG_DEN + 1);
	localparam int SPEED_THR   = SPEED_MAX * AVG_DEN;

	// reciprocal of AVG_DEN, exact for dividends below 2**X_W
	localparam int     DIV_K = X_W + $clog2(AVG_DEN);
	localparam longint DIV_M = ((longint'(1) << DIV_K) + AVG_DEN - 1) / AVG_DEN;
	localparam int     M_W   = $clog2(DIV_M + 1);
	localparam int     P_W   = X_W + M_W;

	// angle: sum * ANGLE_SPAN * DIV_M in one constant product
	localparam longint ANG_C   = longint'(ANGLE_SPAN) * DIV_M;
	localparam int     ANG_P_W = SUM_W + $clog2(ANG_C + 1);

	localparam int QS_W  = $clog2(SPEED_SPAN + 1);
	localparam int SPD_W = QS_W + 1;
	localparam int QA_W  = $clog2(ANGLE_SPAN + 1);

	// motor: abs * MOTOR_TOP / SPEED_MAX by reciprocal
	localparam int     MOT_N   = $clog2(SPEED_MAX * MOTOR_TOP + 1);
	localparam int     MOT_K   = MOT_N + $clog2(SPEED_MAX);
	localparam longint MOT_M   = ((longint'(1) << MOT_K) + SPEED_MAX - 1) / SPEED_MAX;
	localparam longint MOT_C   = longint'(MOTOR_TOP) * MOT_M;
	localparam int     MOT_P_W = ABS_SPEED_W + $clog2(MOT_C + 1);

	// direction bits: bit 0 = in1 (forward), bit 1 = in2 (reverse)
	typedef logic [1:0] dir_t;
	localparam dir_t DIR_FWD = 2'b01;
	localparam dir_t DIR_REV = 2'b10;

endpackage

>>> sv/potsrv_sample_if.sv
// ----------------------------------------------------------------------------
// potsrv_sample_if
// Input channel: one pair of speed and angle ADC samples per transfer.
// ----------------------------------------------------------------------------
interface potsrv_sample_if import potsrv_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic [SPEED_SAMPLE_W-1:0] speed_sample;
	logic [ANGLE_SAMPLE_W-1:0] angle_sample;

	modport source (output valid, output speed_sample, output angle_sample, input ready);
	modport sink   (input valid, input speed_sample, input angle_sample, output ready);
endinterface

>>> sv/potsrv_drive_if.sv
// ----------------------------------------------------------------------------
// potsrv_drive_if
// Output channel: speed/angle settings, H-bridge lines and PWM compare values.
// ----------------------------------------------------------------------------
interface potsrv_drive_if import potsrv_pkg::*; ;
	logic                              valid;
	logic                              ready;
	logic signed [SPEED_SETTING_W-1:0] speed_setting;
	logic        [ABS_SPEED_W-1:0]     abs_speed;
	logic        [ABS_ANGLE_W-1:0]     abs_angle;
	logic signed [ANGLE_SETTING_W-1:0] angle_setting;
	logic                              bridge_in1;
	logic                              bridge_in2;
	logic                              bridge_enable;
	logic        [MOTOR_PULSE_W-1:0]   motor_pulse;
	logic        [SERVO_PULSE_W-1:0]   servo_pulse;

	modport source (output valid, output speed_setting, output abs_speed, output abs_angle,
		output angle_setting, output bridge_in1, output bridge_in2, output bridge_enable,
		output motor_pulse, output servo_pulse, input ready);
	modport sink   (input valid, input speed_setting, input abs_speed, input abs_angle,
		input angle_setting, input bridge_in1, input bridge_in2, input bridge_enable,
		input motor_pulse, input servo_pulse, output ready);
endinterface

>>> sv/potsrv_ram.sv
// ----------------------------------------------------------------------------
// potsrv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module potsrv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/pot_average_to_motor_servo_drive.sv
// ----------------------------------------------------------------------------
// pot_average_to_motor_servo_drive
// Moving average of speed/angle pot samples, mapped to H-bridge and servo drive.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one transfer carries a speed and an angle ADC sample pair.
//   drive:   one transfer per sample pair with speed/angle settings, H-bridge
//            direction and standby lines, motor and servo PWM compare values.
//   Each sample pair enters a ring of the last WINDOW pairs held in a RAM;
//   running sums are kept per channel and the averages are scaled by exact
//   reciprocal multiplication.
//   Pipeline: a result is offered on drive from the last of five registered
//   stages (ring read, sum update with span products, reciprocal multiply,
//   settings, output product).
//   Throughput: one pair per cycle while drive keeps ready high; the ring RAM is
//   read and written at the same slot once per transfer; running sums update per pair.
//   Reset: ring contents read as zero (per-slot valid flags), sums, ring
//   position and direction bits clear; no clearing pass is needed.
//   Stall: each of the 5 stages holds when its successor is full; samples
//   ready stays high while any stage has room, so new pairs keep entering
//   while a finished result waits on drive.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pot_average_to_motor_servo_drive import potsrv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	potsrv_sample_if.sink    samples,
	potsrv_drive_if.source   drive
);

	localparam int RW = 2 * SAMPLE_BITS;

	// ring control
	logic [PTR_W-1:0]       pos_q;
	logic [WINDOW-1:0]      slot_vld_q;
	logic [SUM_W-1:0]       sum0_q, sum1_q;
	dir_t                   dir_q;
	logic [RW-1:0]          ring_rdata;
	logic                   accept;

	logic [SAMPLE_BITS-1:0] spd_in, ang_in;

	// stage valids and readies
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	// stage payloads
	logic [SAMPLE_BITS-1:0]    spd_s1, ang_s1;
	logic                      old_ok_s1;
	logic [X_W-1:0]            x0_s2;
	logic [ANG_P_W-1:0]        angp_s2;
	logic [P_W-1:0]            p0_s3;
	logic [QA_W-1:0]           ang_s3;
	logic signed [SPD_W-1:0]   spd_s4;
	logic [ABS_SPEED_W-1:0]    abs_s4;
	logic [QA_W-1:0]           ang_s4;
	logic signed [ANGLE_SETTING_W-1:0] angset_s4;
	dir_t                      dir_s4;
	logic                      en_s4;
	logic [SERVO_PULSE_W-1:0]  servo_s4;
	logic signed [SPD_W-1:0]   spd_s5;
	logic [ABS_SPEED_W-1:0]    abs_s5;
	logic [QA_W-1:0]           ang_s5;
	logic signed [ANGLE_SETTING_W-1:0] angset_s5;
	dir_t                      dir_s5;
	logic                      en_s5;
	logic [SERVO_PULSE_W-1:0]  servo_s5;
	logic [MOT_P_W-1:0]        motp_s5;

	// combinational
	logic [SAMPLE_BITS-1:0]  old_spd, old_ang;
	logic [SUM_W-1:0]        nsum0, nsum1;
	logic [X_W-1:0]          x0c;
	logic [QS_W-1:0]         q0;
	logic signed [SPD_W-1:0] spd_c;
	logic [ABS_SPEED_W-1:0]  abs_c;
	dir_t                    dir_nxt;

	assign spd_in = SAMPLE_BITS'(samples.speed_sample);
	assign ang_in = SAMPLE_BITS'(samples.angle_sample);

	assign rdy_s5 = !v_s5 || drive.ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign samples.ready = rdy_s1;
	assign accept        = samples.valid && rdy_s1;

	// read-before-write at the same slot: rdata returns the sample being replaced
	potsrv_ram #(
		.WIDTH(RW),
		.DEPTH(WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (accept),
		.waddr(pos_q),
		.wdata({spd_in, ang_in}),
		.re   (accept),
		.raddr(pos_q),
		.rdata(ring_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			slot_vld_q <= '0;
			old_ok_s1  <= 1'b0;
		end else if (accept) begin
			slot_vld_q[pos_q] <= 1'b1;
			old_ok_s1         <= slot_vld_q[pos_q];
			if (pos_q == PTR_W'(WINDOW - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			sum0_q <= '0;
			sum1_q <= '0;
			dir_q  <= '0;
		end else begin
			if (rdy_s1) v_s1 <= samples.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (v_s1 && rdy_s2) begin
				sum0_q <= nsum0;
				sum1_q <= nsum1;
			end
			// direction follows each transfer into stage 4
			if (v_s3 && rdy_s4) begin
				dir_q <= dir_nxt;
			end
		end
	end

	// stage 1: running sums
	assign old_spd = old_ok_s1 ? ring_rdata[RW-1:SAMPLE_BITS] : '0;
	assign old_ang = old_ok_s1 ? ring_rdata[SAMPLE_BITS-1:0] : '0;
	assign nsum0   = sum0_q - SUM_W'(old_spd) + SUM_W'(spd_s1);
	assign nsum1   = sum1_q - SUM_W'(old_ang) + SUM_W'(ang_s1);

	// stage 3: round up for negative speeds so the quotient truncates toward zero
	assign x0c = (x0_s2 >= X_W'(SPEED_THR)) ? x0_s2 : X_W'(x0_s2 + X_W'(AVG_DEN - 1));

	// stage 4: settings and direction
	assign q0      = QS_W'(p0_s3 >> DIV_K);
	assign spd_c   = $signed({1'b0, q0}) - $signed(SPD_W'(SPEED_MAX));
	assign abs_c   = spd_c[SPD_W-1] ? ABS_SPEED_W'(-spd_c) : ABS_SPEED_W'(spd_c);

	always_comb begin
		dir_nxt = dir_q;
		if (spd_c[SPD_W-1]) begin
			dir_nxt = DIR_REV;
		end else if (spd_c != '0) begin
			dir_nxt = DIR_FWD;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			spd_s1 <= spd_in;
			ang_s1 <= ang_in;
		end
		if (rdy_s2) begin
			x0_s2   <= X_W'(nsum0 * SPEED_SPAN);
			angp_s2 <= ANG_P_W'(longint'(nsum1) * ANG_C);
		end
		if (rdy_s3) begin
			p0_s3  <= P_W'(longint'(x0c) * DIV_M);
			ang_s3 <= QA_W'(angp_s2 >> DIV_K);
		end
		if (rdy_s4) begin
			spd_s4    <= spd_c;
			abs_s4    <= abs_c;
			ang_s4    <= ang_s3;
			angset_s4 <= ANGLE_SETTING_W'($signed({1'b0, ang_s3}) - ANGLE_MID);
			dir_s4    <= dir_nxt;
			en_s4     <= (spd_c != '0);
			servo_s4  <= SERVO_PULSE_W'(ang_s3 * SERVO_STEP + SERVO_BASE);
		end
		if (rdy_s5) begin
			spd_s5    <= spd_s4;
			abs_s5    <= abs_s4;
			ang_s5    <= ang_s4;
			angset_s5 <= angset_s4;
			dir_s5    <= dir_s4;
			en_s5     <= en_s4;
			servo_s5  <= servo_s4;
			motp_s5   <= MOT_P_W'(longint'(abs_s4) * MOT_C);
		end
	end

	assign drive.valid         = v_s5;
	assign drive.speed_setting = SPEED_SETTING_W'(spd_s5);
	assign drive.abs_speed     = abs_s5;
	assign drive.abs_angle     = ABS_ANGLE_W'(ang_s5);
	assign drive.angle_setting = angset_s5;
	assign drive.bridge_in1    = dir_s5[0];
	assign drive.bridge_in2    = dir_s5[1];
	assign drive.bridge_enable = en_s5;
	assign drive.motor_pulse   = MOTOR_PULSE_W'(motp_s5 >> MOT_K);
	assign drive.servo_pulse   = servo_s5;

	`POTSRV_ASSERT(a_enable_speed, drive.valid |-> (drive.bridge_enable == (drive.speed_setting != '0)), "standby line disagrees with speed")
	`POTSRV_ASSERT(a_dir_onehot0, $onehot0(dir_q), "both direction bits set")
	`POTSRV_ASSERT(a_sum_range, (sum0_q <= SUM_W'(AVG_DEN)) && (sum1_q <= SUM_W'(AVG_DEN)), "running sum out of range")
	`POTSRV_ASSERT_NEXT(a_ring_hold, v_s1 && !rdy_s2, $stable(ring_rdata), "ring read data lost during stall")

endmodule

>>> test/tb_pot_average_to_motor_servo_drive.sv
// ----------------------------------------------------------------------------
// tb_pot_average_to_motor_servo_drive
// Self-checking bench for the pot average to motor/servo drive. Sample pairs
// go in with random gaps and come out against random drive stalls, with one
// long drive hold-off that backs the block up. A behavioral copy of the
// moving average and the drive mapping predicts each transfer on the drive
// side. Every field is compared in order.
// ----------------------------------------------------------------------------
module tb_pot_average_to_motor_servo_drive;
	import potsrv_pkg::*;

	typedef struct {
		logic signed [SPEED_SETTING_W-1:0] speed_setting;
		logic        [ABS_SPEED_W-1:0]     abs_speed;
		logic        [ABS_ANGLE_W-1:0]     abs_angle;
		logic signed [ANGLE_SETTING_W-1:0] angle_setting;
		logic                              bridge_in1;
		logic                              bridge_in2;
		logic                              bridge_enable;
		logic        [MOTOR_PULSE_W-1:0]   motor_pulse;
		logic        [SERVO_PULSE_W-1:0]   servo_pulse;
	} drive_t;

	class drive_scoreboard;
		int     speed_hist[WINDOW];
		int     angle_hist[WINDOW];
		int     slot;
		int     speed_total;
		int     angle_total;
		dir_t   dir;
		drive_t expected_drive_q[$];
		int     errors;

		function new();
			foreach (speed_hist[i]) begin
				speed_hist[i] = 0;
				angle_hist[i] = 0;
			end
			slot        = 0;
			speed_total = 0;
			angle_total = 0;
			dir         = '0;
			errors      = 0;
		endfunction

		function void add_sample_pair(logic [SPEED_SAMPLE_W-1:0] spd,
			logic [ANGLE_SAMPLE_W-1:0] ang);
			longint num;
			int     setting;
			int     mag;
			int     ang_abs;
			drive_t exp_r;
			speed_total = speed_total - speed_hist[slot] + int'(spd & FULL_SCALE);
			angle_total = angle_total - angle_hist[slot] + int'(ang & FULL_SCALE);
			speed_hist[slot] = int'(spd & FULL_SCALE);
			angle_hist[slot] = int'(ang & FULL_SCALE);
			slot = (slot + 1) % WINDOW;
			// signed divide truncates toward zero
			num     = longint'(speed_total) * SPEED_SPAN - longint'(SPEED_MAX) * AVG_DEN;
			setting = int'(num / AVG_DEN);
			mag     = (setting < 0) ? -setting : setting;
			ang_abs = int'(longint'(angle_total) * ANGLE_SPAN / AVG_DEN);
			if (setting > 0) begin
				dir = DIR_FWD;
			end else if (setting < 0) begin
				dir = DIR_REV;
			end
			exp_r.speed_setting = SPEED_SETTING_W'(setting);
			exp_r.abs_speed     = ABS_SPEED_W'(mag);
			exp_r.abs_angle     = ABS_ANGLE_W'(ang_abs);
			exp_r.angle_setting = ANGLE_SETTING_W'(ang_abs - ANGLE_MID);
			exp_r.bridge_in1    = dir[0];
			exp_r.bridge_in2    = dir[1];
			exp_r.bridge_enable = (setting != 0);
			exp_r.motor_pulse   = MOTOR_PULSE_W'(mag * MOTOR_TOP / SPEED_MAX);
			exp_r.servo_pulse   = SERVO_PULSE_W'(ang_abs * SERVO_STEP + SERVO_BASE);
			expected_drive_q.push_back(exp_r);
		endfunction

		function void compare(string name, logic signed [15:0] want, logic signed [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_drive(drive_t got);
			drive_t want;
			if (expected_drive_q.size() == 0) begin
				$error("drive transfer with nothing expected");
				errors++;
				return;
			end
			want = expected_drive_q.pop_front();
			compare("speed_setting", want.speed_setting, got.speed_setting);
			compare("abs_speed", want.abs_speed, got.abs_speed);
			compare("abs_angle", want.abs_angle, got.abs_angle);
			compare("angle_setting", want.angle_setting, got.angle_setting);
			compare("bridge_in1", want.bridge_in1, got.bridge_in1);
			compare("bridge_in2", want.bridge_in2, got.bridge_in2);
			compare("bridge_enable", want.bridge_enable, got.bridge_enable);
			compare("motor_pulse", want.motor_pulse, got.motor_pulse);
			compare("servo_pulse", want.servo_pulse, got.servo_pulse);
		endfunction

		function int pending();
			return expected_drive_q.size();
		endfunction
	endclass

	localparam int RANDOM_PAIRS = 600;
	localparam int HOLD_CYCLES  = 120;

	logic clk;
	logic arst_n;

	potsrv_sample_if sample_ch ();
	potsrv_drive_if  drive_ch ();

	pot_average_to_motor_servo_drive i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.drive   (drive_ch)
	);

	drive_scoreboard drive_model;
	int              pairs_sent;
	bit              held_off;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pick_idle();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70) begin
			return 0;
		end
		if (p < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SPEED_SAMPLE_W-1:0] jitter(int base, int spread);
		int v;
		v = base - spread + int'($urandom_range(0, 2 * spread));
		if (v < 0) begin
			v = 0;
		end
		if (v > FULL_SCALE) begin
			v = FULL_SCALE;
		end
		return SPEED_SAMPLE_W'(v);
	endfunction

	task automatic send_pair(input logic [SPEED_SAMPLE_W-1:0] spd,
		input logic [ANGLE_SAMPLE_W-1:0] ang, input bit calm);
		int gap;
		gap = calm ? 0 : pick_idle();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid        <= 1'b1;
		sample_ch.speed_sample <= spd;
		sample_ch.angle_sample <= ang;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1) @(posedge clk);
		drive_model.add_sample_pair(spd, ang);
		pairs_sent++;
	endtask

	// drive side back-pressure
	initial begin
		int stall_left;
		int hold_left;
		int cyc;
		bit calm_rx;
		stall_left     = 0;
		hold_left      = 0;
		cyc            = 0;
		calm_rx        = 1'b0;
		drive_ch.ready = 1'b0;
		held_off       = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0) begin
				calm_rx = ($urandom_range(0, 2) == 0);
			end
			if (hold_left > 0) begin
				drive_ch.ready <= 1'b0;
				hold_left--;
			end else if (!held_off && pairs_sent >= 200) begin
				held_off = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				drive_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				drive_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				drive_ch.ready <= 1'b1;
				if (!calm_rx && arst_n) begin
					stall_left = pick_idle();
				end
			end
		end
	end

	always @(posedge clk) begin
		drive_t got;
		if (arst_n && drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1) begin
			got.speed_setting = drive_ch.speed_setting;
			got.abs_speed     = drive_ch.abs_speed;
			got.abs_angle     = drive_ch.abs_angle;
			got.angle_setting = drive_ch.angle_setting;
			got.bridge_in1    = drive_ch.bridge_in1;
			got.bridge_in2    = drive_ch.bridge_in2;
			got.bridge_enable = drive_ch.bridge_enable;
			got.motor_pulse   = drive_ch.motor_pulse;
			got.servo_pulse   = drive_ch.servo_pulse;
			drive_model.check_drive(got);
		end
	end

	initial begin
		#2000000;
		$display("tb_pot_average_to_motor_servo_drive: FAIL");
		$finish;
	end

	initial begin
		int random_pairs;
		int kind;
		int len;
		int sbase;
		int abase;
		int sspread;
		int aspread;
		int waited;
		bit calm;
		drive_model            = new();
		pairs_sent             = 0;
		arst_n                 = 1'b0;
		sample_ch.valid        = 1'b0;
		sample_ch.speed_sample = '0;
		sample_ch.angle_sample = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// warm-up from cleared rings up to full forward and full angle
		repeat (10) send_pair(SPEED_SAMPLE_W'(FULL_SCALE), ANGLE_SAMPLE_W'(FULL_SCALE), 1'b0);
		// mid-scale average: zero speed, forward direction held, standby low
		for (int i = 0; i < 10; i++) begin
			send_pair(i[0] ? 10'd512 : 10'd511, i[0] ? 10'd511 : 10'd512, 1'b0);
		end
		// toward full reverse and angle zero
		repeat (5) send_pair('0, '0, 1'b0);

		random_pairs = 0;
		while (random_pairs < RANDOM_PAIRS) begin
			kind = $urandom_range(0, 9);
			calm = ($urandom_range(0, 3) == 0);
			if (kind <= 4) begin
				sbase   = $urandom_range(0, FULL_SCALE);
				abase   = $urandom_range(0, FULL_SCALE);
				sspread = 8;
				aspread = 8;
				len     = $urandom_range(10, 25);
			end else if (kind <= 6) begin
				// hover around zero speed
				sbase   = $urandom_range(505, 518);
				abase   = $urandom_range(0, FULL_SCALE);
				sspread = 2;
				aspread = 4;
				len     = $urandom_range(10, 20);
			end else if (kind == 7) begin
				sbase   = $urandom_range(0, 1) ? FULL_SCALE : 0;
				abase   = $urandom_range(0, 1) ? FULL_SCALE : 0;
				sspread = 0;
				aspread = 0;
				len     = 12;
			end else begin
				sbase   = 512;
				abase   = 512;
				sspread = 512;
				aspread = 512;
				len     = $urandom_range(5, 15);
			end
			for (int i = 0; i < len; i++) begin
				send_pair(jitter(sbase, sspread), jitter(abase, aspread), calm);
			end
			random_pairs += len;
		end
		sample_ch.valid <= 1'b0;

		waited = 0;
		while (drive_model.pending() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);

		if (drive_model.errors == 0 && drive_model.pending() == 0) begin
			$display("tb_pot_average_to_motor_servo_drive: PASS");
		end else begin
			$display("tb_pot_average_to_motor_servo_drive: FAIL");
		end
		$finish;
	end

endmodule
